@@ hw/rtl/bf_pkg.sv @@
// Shared constants, codes and types of the 3x3 box filter.
// No dependencies; imported by the interfaces and every module.
package bf_pkg;

  // default sizes, handed down as top-level parameters
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int DEF_PIXEL_BITS = 16;

  // fixed field and register widths
  localparam int FW_BITS        = 11;
  localparam int FH_BITS        = 13;
  localparam int MV_BITS        = 16;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int PIX_FIELD_BITS = 16;
  localparam int FILT_BITS      = 16;

  // register values after reset
  localparam logic [FW_BITS-1:0] FW_RESET = FW_BITS'(640);
  localparam logic [FH_BITS-1:0] FH_RESET = FH_BITS'(480);
  localparam logic [MV_BITS-1:0] MV_RESET = MV_BITS'(255);

  // register map
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_MAX_VALUE    = 2'd2
  } cfg_reg_t;

  // input beat kinds
  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_FLUSH = 1'b1
  } kind_t;

  // per-beat control carried down the pipeline
  typedef struct packed {
    logic emit;
    logic interior;
    logic last;
  } bf_meta_t;

endpackage

@@ hw/rtl/bf_stream_if.sv @@
// Valid/ready stream interfaces for the box filter: pixel input and result output.
// Depends on bf_pkg for the field widths.
interface bf_in_if import bf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [PIX_FIELD_BITS-1:0] pixel;

  modport source (output valid, output kind, output pixel, input ready);
  modport sink   (input valid, input kind, input pixel, output ready);
endinterface

interface bf_out_if import bf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [FILT_BITS-1:0] filtered;
  logic                 frame_end;

  modport source (output valid, output filtered, output frame_end, input ready);
  modport sink   (input valid, input filtered, input frame_end, output ready);
endinterface

@@ hw/rtl/bf_line_store.sv @@
// One line store: a single-port-write, single-port-read RAM with registered read data.
// Depends on bf_pkg for default sizes; contents are not cleared by reset.
module bf_line_store import bf_pkg::*; #(
  parameter int DEPTH     = DEF_MAX_WIDTH,
  parameter int DATA_BITS = DEF_PIXEL_BITS
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [DATA_BITS-1:0]       rd_data,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [DATA_BITS-1:0]       wr_data
);

  logic [DATA_BITS-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/bf_cell.sv @@
// One window cell: holds a three-row column of the 3x3 window and its column sum.
// Depends on bf_pkg for the default pixel width; chained by the top level.
module bf_cell import bf_pkg::*; #(
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       shift,
  input  logic [2:0][PIXEL_BITS-1:0] col_in,
  output logic [2:0][PIXEL_BITS-1:0] col,
  output logic [PIXEL_BITS+1:0]      col_sum
);

  // take the neighbour's column on a shift, summing it on the way in
  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      col_sum <= '0;
    end else if (shift) begin
      col     <= col_in;
      col_sum <= (PIXEL_BITS+2)'(col_in[0]) + (PIXEL_BITS+2)'(col_in[1])
               + (PIXEL_BITS+2)'(col_in[2]);
    end
  end

endmodule

@@ hw/rtl/box_filter_3x3_border_copy_core.sv @@
// 3x3 box (mean) filter with border copy over a raster-order grey pixel stream.
// Throughput: one beat per clock, pixel or flush, unless the output stalls; line stores
// are read only on beats that shift the window. A result passes stages 1 to 4 and the
// output register; the beat causing it is frame_width+1 pixels behind the window centre.
// Reset (rst, synchronous): counters, window and configuration registers cleared to their reset
// values at once; line store contents are left as they are and are never cleared.
module box_filter_3x3_border_copy_core import bf_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  bf_in_if.sink                     stream_in,
  bf_out_if.source                  stream_out
);

  localparam int CB  = $clog2(MAX_WIDTH);
  localparam int WB  = $clog2(MAX_WIDTH + 1);
  localparam int RB  = $clog2(MAX_HEIGHT + 1);
  localparam int PB  = PIXEL_BITS;
  localparam int CSB = PB + 2;
  localparam int SB  = PB + 4;
  // divide by nine as multiply by a rounded-up reciprocal and shift
  localparam int RK  = SB + 4;
  localparam int MW  = RK - 2;
  localparam logic [MW-1:0] Recip9 = MW'(((64'd1 << RK) + 64'd8) / 64'd9);

  // configuration registers
  logic [FW_BITS-1:0] frame_width;
  logic [FH_BITS-1:0] frame_height;
  logic [MV_BITS-1:0] max_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_RESET;
      frame_height <= FH_RESET;
      max_value    <= MV_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_BITS-1:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg_data[FH_BITS-1:0];
        CFG_MAX_VALUE:    max_value    <= cfg_data[MV_BITS-1:0];
        default: ;
      endcase
    end
  end

  // frame size saturated to the supported range
  logic [WB-1:0] eff_w;
  logic [RB-1:0] eff_h;

  always_comb begin
    if (frame_width < FW_BITS'(3)) begin
      eff_w = WB'(3);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      eff_w = WB'(MAX_WIDTH);
    end else begin
      eff_w = WB'(frame_width);
    end
    if (frame_height < FH_BITS'(3)) begin
      eff_h = RB'(3);
    end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      eff_h = RB'(MAX_HEIGHT);
    end else begin
      eff_h = RB'(frame_height);
    end
  end

  // raster counters
  logic [CB-1:0] in_column, out_column, in_column_next, out_column_next;
  logic [RB-1:0] in_row, out_row, in_row_next, out_row_next;

  // pipeline advance: everything moves unless a result is stuck at the output
  logic out_valid;
  logic adv, acc;

  assign adv             = !out_valid || stream_out.ready;
  assign acc             = stream_in.valid && adv;
  assign stream_in.ready = adv;

  // beat decode and counter update
  logic          is_pixel, complete, col_wrap, out_wrap, produce;
  logic          shift0, write0, emit0, interior0, last0;
  logic [CB-1:0] flush_col, addr0;

  always_comb begin
    is_pixel  = (stream_in.kind == KIND_PIXEL);
    complete  = (in_row >= eff_h);
    col_wrap  = ((WB+1)'(in_column) + (WB+1)'(1)) >= (WB+1)'(eff_w);
    out_wrap  = ((WB+1)'(out_column) + (WB+1)'(1)) >= (WB+1)'(eff_w);
    flush_col = out_wrap ? '0 : out_column + CB'(1);
    produce   = (in_row >= RB'(2)) || ((in_row == RB'(1)) && (in_column >= CB'(1)));
    shift0    = is_pixel ? !complete : complete;
    write0    = is_pixel && !complete;
    emit0     = is_pixel ? (!complete && produce) : complete;
    addr0     = is_pixel ? in_column : flush_col;
    interior0 = (out_row >= RB'(1))
             && (((RB+1)'(out_row) + (RB+1)'(2)) <= (RB+1)'(eff_h))
             && (out_column >= CB'(1))
             && (((WB+1)'(out_column) + (WB+1)'(2)) <= (WB+1)'(eff_w));
    last0     = ((((RB+1)'(out_row) + (RB+1)'(1)) >= (RB+1)'(eff_h)) && out_wrap)
             || (out_row >= eff_h);

    in_column_next  = in_column;
    in_row_next     = in_row;
    out_column_next = out_column;
    out_row_next    = out_row;
    if (acc) begin
      if (write0) begin
        if (col_wrap) begin
          in_column_next = '0;
          in_row_next    = in_row + RB'(1);
        end else begin
          in_column_next = in_column + CB'(1);
        end
      end
      if (emit0) begin
        priority if (last0) begin
          in_column_next  = '0;
          in_row_next     = '0;
          out_column_next = '0;
          out_row_next    = '0;
        end else if (out_wrap) begin
          out_column_next = '0;
          out_row_next    = out_row + RB'(1);
        end else begin
          out_column_next = out_column + CB'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
    end
  end

  // stage 1: line store read, beat control
  logic          s1_shift, s1_write;
  bf_meta_t      s1_meta;
  logic [CB-1:0] s1_addr;
  logic [PB-1:0] s1_bottom;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_shift <= 1'b0;
      s1_write <= 1'b0;
      s1_meta  <= '0;
    end else if (adv) begin
      s1_shift         <= acc && shift0;
      s1_write         <= acc && write0;
      s1_meta.emit     <= acc && emit0;
      s1_meta.interior <= interior0;
      s1_meta.last     <= last0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_addr   <= addr0;
      s1_bottom <= is_pixel ? stream_in.pixel[PB-1:0] : '0;
    end
  end

  // line stores: older takes prior's old value, prior takes the new pixel
  logic          rd_en, wr_en;
  logic [PB-1:0] older_q, prior_q, older_b, prior_b;
  logic          fwd_hit;
  logic [PB-1:0] fwd_older, fwd_prior;

  assign rd_en = acc && shift0;
  assign wr_en = adv && s1_write;

  bf_line_store #(.DEPTH(MAX_WIDTH), .DATA_BITS(PB)) u_older (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (addr0),
    .rd_data (older_q),
    .wr_en   (wr_en),
    .wr_addr (s1_addr),
    .wr_data (prior_b)
  );

  bf_line_store #(.DEPTH(MAX_WIDTH), .DATA_BITS(PB)) u_prior (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (addr0),
    .rd_data (prior_q),
    .wr_en   (wr_en),
    .wr_addr (s1_addr),
    .wr_data (s1_bottom)
  );

  // bypass for a read of the column being written back in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (rd_en) begin
      fwd_hit <= wr_en && (s1_addr == addr0);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_older <= prior_b;
      fwd_prior <= s1_bottom;
    end
  end

  assign older_b = fwd_hit ? fwd_older : older_q;
  assign prior_b = fwd_hit ? fwd_prior : prior_q;

  // stage 2: window as a chain of three column cells, newest column enters cell 2
  logic [2:0][PB-1:0] col_new;
  logic [2:0][PB-1:0] cell_in  [3];
  logic [2:0][PB-1:0] cell_col [3];
  logic [CSB-1:0]     cell_sum [3];
  logic               cell_shift;

  assign col_new    = {s1_bottom, prior_b, older_b};
  assign cell_in[0] = cell_col[1];
  assign cell_in[1] = cell_col[2];
  assign cell_in[2] = col_new;
  assign cell_shift = adv && s1_shift;

  for (genvar i = 0; i < 3; i++) begin : g_cell
    bf_cell #(.PIXEL_BITS(PB)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (cell_shift),
      .col_in  (cell_in[i]),
      .col     (cell_col[i]),
      .col_sum (cell_sum[i])
    );
  end

  bf_meta_t s2_meta, s3_meta, s4_meta;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_meta <= '0;
      s3_meta <= '0;
      s4_meta <= '0;
    end else if (adv) begin
      s2_meta <= s1_meta;
      s3_meta <= s2_meta;
      s4_meta <= s3_meta;
    end
  end

  // stage 3: window total; stage 4: divide by nine
  logic [SB-1:0]    s3_sum;
  logic [PB-1:0]    s3_center, s4_center, s4_quot;
  logic [SB+MW-1:0] prod;

  assign prod = (SB+MW)'(s3_sum) * (SB+MW)'(Recip9);

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_sum    <= SB'(cell_sum[0]) + SB'(cell_sum[1]) + SB'(cell_sum[2]);
      s3_center <= cell_col[1][1];
      s4_quot   <= prod[RK+PB-1:RK];
      s4_center <= s3_center;
    end
  end

  // output register: clamp smoothed values, copy border pixels
  logic                 out_last, out_smooth;
  logic [FILT_BITS-1:0] out_value;
  logic [MV_BITS-1:0]   quot_ext;

  assign quot_ext = MV_BITS'(s4_quot);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s4_meta.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_last   <= s4_meta.last;
      out_smooth <= s4_meta.interior;
      if (s4_meta.interior) begin
        out_value <= FILT_BITS'((quot_ext > max_value) ? max_value : quot_ext);
      end else begin
        out_value <= FILT_BITS'(s4_center);
      end
    end
  end

  assign stream_out.valid     = out_valid;
  assign stream_out.filtered  = out_value;
  assign stream_out.frame_end = out_last && out_smooth | out_last;

`ifndef NO_ASSERTIONS
  // the frame's last result restarts all four counters
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (acc && emit0 && last0) |=>
      (in_column == '0 && in_row == '0 && out_column == '0 && out_row == '0))
    else $error("counters not restarted after frame end");

  // a dropped beat leaves the raster position alone
  a_drop_holds: assert property (@(posedge clk) disable iff (rst)
    (acc && !shift0) |=>
      ($stable(in_column) && $stable(in_row) && $stable(out_column) && $stable(out_row)))
    else $error("dropped beat moved the counters");

  // a result-bearing beat reaches the output while the pipeline keeps advancing
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (acc && emit0) ##1 adv ##1 adv ##1 adv ##1 adv |=> out_valid)
    else $error("result lost in the pipeline");
`endif

endmodule

@@ tb/tb_box_filter_3x3_border_copy_core.sv @@
// Self-checking bench for the 3x3 box filter core with border copy.
// Depends on bf_pkg, the bf_in_if/bf_out_if stream interfaces and the core itself;
// a built-in predictor checks every output beat against its own expectation.
module tb_box_filter_3x3_border_copy_core;
  import bf_pkg::*;

  localparam int WINDOW_TAPS   = 9;
  localparam int SHOWN_ERRORS  = 10;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_BEATS  = 1150;
  localparam int RUN_LIMIT     = 2_000_000;

  typedef struct packed {
    kind_t                     kind;
    logic [PIX_FIELD_BITS-1:0] pixel;
  } pix_beat_t;

  typedef struct packed {
    logic [FILT_BITS-1:0] filtered;
    logic                 frame_end;
  } smoothed_t;

  // clock, reset and DUT-facing drive registers
  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      cfg_we    = 1'b0;
  cfg_reg_t                  cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
  logic                      in_valid  = 1'b0;
  kind_t                     in_kind   = KIND_PIXEL;
  logic [PIX_FIELD_BITS-1:0] in_pixel  = '0;
  logic                      out_ready = 1'b0;

  // traffic shaping
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  logic        hold_off      = 1'b0;
  logic        start_hold    = 1'b0;

  // predictor state: line stores, window [column][row] with column 0 oldest
  logic [PIX_FIELD_BITS-1:0] older_row [DEF_MAX_WIDTH];
  logic [PIX_FIELD_BITS-1:0] prior_row [DEF_MAX_WIDTH];
  logic [PIX_FIELD_BITS-1:0] win [3][3];
  int unsigned               in_col, in_row, out_col, out_row;
  logic [FW_BITS-1:0]        width_reg;
  logic [FH_BITS-1:0]        height_reg;
  logic [MV_BITS-1:0]        max_reg;

  pix_beat_t   stim_beats [$];
  smoothed_t   expected_px [$];
  int unsigned mismatches    = 0;
  int unsigned beats_in      = 0;
  int unsigned beats_dropped = 0;
  int unsigned results_seen  = 0;
  int unsigned frames_done   = 0;

  bf_in_if  in_if ();
  bf_out_if out_if ();

  assign in_if.valid  = in_valid;
  assign in_if.kind   = in_kind;
  assign in_if.pixel  = in_pixel;
  assign out_if.ready = out_ready;

  box_filter_3x3_border_copy_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .stream_in  (in_if),
    .stream_out (out_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic reset_model();
    for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
      older_row[i] = '0;
      prior_row[i] = '0;
    end
    for (int c = 0; c < 3; c++)
      for (int r = 0; r < 3; r++)
        win[c][r] = '0;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    width_reg  = FW_RESET;
    height_reg = FH_RESET;
    max_reg    = MV_RESET;
  endtask

  task automatic shift_window(input logic [PIX_FIELD_BITS-1:0] top, mid, bot);
    for (int r = 0; r < 3; r++) begin
      win[0][r] = win[1][r];
      win[1][r] = win[2][r];
    end
    win[2][0] = top;
    win[2][1] = mid;
    win[2][2] = bot;
  endtask

  // produce the output pixel at (out_row, out_col) and advance the output counters
  task automatic emit_smoothed(input int unsigned w, input int unsigned h);
    int unsigned sum;
    int unsigned value;
    logic        last;
    smoothed_t   res;
    value = win[1][1];
    if (out_row >= 1 && out_row + 2 <= h && out_col >= 1 && out_col + 2 <= w) begin
      sum = 0;
      for (int c = 0; c < 3; c++)
        for (int r = 0; r < 3; r++)
          sum += win[c][r];
      value = sum / WINDOW_TAPS;
      if (value > max_reg) value = max_reg;
    end
    last = (out_row + 1 >= h && out_col + 1 >= w) || out_row >= h;
    res.filtered  = value[FILT_BITS-1:0];
    res.frame_end = last;
    expected_px.push_back(res);
    if (last) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      frames_done++;
    end else if (out_col + 1 >= w) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
  endtask

  // one accepted input beat: update state, queue whatever result it causes
  task automatic smooth_beat(input kind_t kind, input logic [PIX_FIELD_BITS-1:0] pixel);
    int unsigned               w, h, col;
    logic                      complete, produce;
    logic [PIX_FIELD_BITS-1:0] a, b;
    w = clamp_size(width_reg, DEF_MAX_WIDTH);
    h = clamp_size(height_reg, DEF_MAX_HEIGHT);
    complete = in_row >= h;
    a = '0;
    b = '0;
    if (kind == KIND_PIXEL) begin
      // pixels past the end of the frame are dropped until the drain is done
      if (complete) begin
        beats_dropped++;
        return;
      end
      col = in_col;
      if (col < DEF_MAX_WIDTH) begin
        a = older_row[col];
        b = prior_row[col];
        older_row[col] = b;
        prior_row[col] = pixel;
      end
      shift_window(a, b, pixel);
      produce = in_row >= 2 || (in_row == 1 && in_col >= 1);
      if (in_col + 1 >= w) begin
        in_col = 0;
        in_row++;
      end else begin
        in_col++;
      end
      if (produce) emit_smoothed(w, h);
    end else begin
      // a flush before the last pixel of the frame does nothing
      if (!complete) begin
        beats_dropped++;
        return;
      end
      col = (out_col + 1 >= w) ? 0 : out_col + 1;
      if (col < DEF_MAX_WIDTH) begin
        a = older_row[col];
        b = prior_row[col];
      end
      shift_window(a, b, '0);
      emit_smoothed(w, h);
    end
  endtask

  task automatic report(input string what, input logic [FILT_BITS-1:0] want, got);
    mismatches++;
    if (mismatches <= SHOWN_ERRORS)
      $display("ERROR output beat %0d, %s: expected %0d, got %0d",
               results_seen, what, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: a beat from the queue, or a random idle, whenever the slot is free
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_beats
    pix_beat_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_if.ready) begin
      if (stim_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = stim_beats.pop_front();
        in_valid <= 1'b1;
        in_kind  <= nxt.kind;
        in_pixel <= nxt.pixel;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output back-pressure, random or held off
  always @(posedge clk) begin : sink_ready
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end
  end

  // long receiver hold-off so the core fills up and stalls its input
  initial begin : hold_window
    wait (start_hold);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Monitor: register writes, accepted input beats, checked output beats
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    smoothed_t want;
    if (rst) begin
      reset_model();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:  width_reg  = cfg_data[FW_BITS-1:0];
          CFG_FRAME_HEIGHT: height_reg = cfg_data[FH_BITS-1:0];
          CFG_MAX_VALUE:    max_reg    = cfg_data[MV_BITS-1:0];
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        beats_in++;
        smooth_beat(kind_t'(in_if.kind), in_if.pixel);
      end
      if (out_if.valid && out_ready) begin
        if (expected_px.size() == 0) begin
          report("beat with nothing expected", '0, out_if.filtered);
        end else begin
          want = expected_px.pop_front();
          if (out_if.filtered !== want.filtered)
            report("filtered", want.filtered, out_if.filtered);
          if (out_if.frame_end !== want.frame_end)
            report("frame_end", FILT_BITS'(want.frame_end), FILT_BITS'(out_if.frame_end));
        end
        results_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_BITS-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    @(posedge clk);
    send_idle_pct <= send_pct;
    stall_pct     <= recv_pct;
  endtask

  task automatic push_beat(input kind_t kind, input logic [PIX_FIELD_BITS-1:0] pixel);
    pix_beat_t b;
    b.kind  = kind;
    b.pixel = pixel;
    stim_beats.push_back(b);
  endtask

  task automatic push_flushes(input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      push_beat(KIND_FLUSH, PIX_FIELD_BITS'($urandom));
  endtask

  function automatic logic [PIX_FIELD_BITS-1:0] rand_pixel();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return PIX_FIELD_BITS'($urandom_range(255));
      default: return PIX_FIELD_BITS'($urandom_range(65535));
    endcase
  endfunction

  // wait until every beat is in, every result out, and the pipeline is empty
  task automatic settle();
    while (stim_beats.size() != 0 || in_valid) @(posedge clk);
    while (expected_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned w_eff, h_eff, reg_w, reg_h, gen_beats, frame_no, n;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // smallest frame, full clamp range; early flush first, extra pixel after the last
    write_reg(CFG_FRAME_WIDTH, 3);
    write_reg(CFG_FRAME_HEIGHT, 3);
    write_reg(CFG_MAX_VALUE, 65535);
    push_beat(KIND_FLUSH, 16'hFFFF);
    push_beat(KIND_PIXEL, 16'h0000);
    push_beat(KIND_PIXEL, 16'hFFFF);
    push_beat(KIND_PIXEL, 16'hAAAA);
    push_beat(KIND_PIXEL, 16'h5555);
    push_beat(KIND_PIXEL, 16'hFFFF);
    push_beat(KIND_PIXEL, 16'h0001);
    push_beat(KIND_PIXEL, 16'h8000);
    push_beat(KIND_PIXEL, 16'h7FFF);
    push_beat(KIND_PIXEL, 16'hFFFF);
    push_beat(KIND_PIXEL, 16'h1234);
    push_flushes(5);
    settle();

    // sizes below the minimum saturate to 3; clamp level zero
    write_reg(CFG_FRAME_WIDTH, 0);
    write_reg(CFG_FRAME_HEIGHT, 2);
    write_reg(CFG_MAX_VALUE, 0);
    for (int i = 0; i < 9; i++)
      push_beat(KIND_PIXEL, (i == 4) ? 16'h0000 : 16'hFFFF);
    push_flushes(4);
    settle();

    // oversized width saturates to the full line length; fills every line store entry
    set_idling(32, 32);
    write_reg(CFG_FRAME_WIDTH, 2047);
    write_reg(CFG_FRAME_HEIGHT, 3);
    write_reg(CFG_MAX_VALUE, 1000);
    for (int i = 0; i < 3 * DEF_MAX_WIDTH; i++)
      push_beat(KIND_PIXEL, rand_pixel());
    push_flushes(DEF_MAX_WIDTH + 1);
    settle();

    // oversized height, then cut short mid frame: the frame ends at once
    set_idling(76, 0);
    write_reg(CFG_FRAME_WIDTH, 3);
    write_reg(CFG_FRAME_HEIGHT, 8191);
    write_reg(CFG_MAX_VALUE, 65535);
    for (int i = 0; i < 18; i++)
      push_beat(KIND_PIXEL, rand_pixel());
    settle();
    write_reg(CFG_FRAME_HEIGHT, 1);
    push_flushes(6);
    settle();

    // width narrowed mid frame: the column counters wrap at once
    set_idling(0, 76);
    write_reg(CFG_FRAME_WIDTH, 8);
    write_reg(CFG_FRAME_HEIGHT, 6);
    for (int i = 0; i < 29; i++)
      push_beat(KIND_PIXEL, rand_pixel());
    settle();
    write_reg(CFG_FRAME_WIDTH, 4);
    for (int i = 0; i < 10; i++)
      push_beat(KIND_PIXEL, rand_pixel());
    push_flushes(12);
    settle();

    // back-pressure: the receiver stops while a full frame is offered
    set_idling(0, 0);
    write_reg(CFG_FRAME_WIDTH, 12);
    write_reg(CFG_FRAME_HEIGHT, 8);
    write_reg(CFG_MAX_VALUE, 255);
    for (int i = 0; i < 96; i++)
      push_beat(KIND_PIXEL, rand_pixel());
    push_flushes(13);
    start_hold <= 1'b1;
    settle();

    // random frames with noise, size changes every few frames
    w_eff = 12;
    h_eff = 8;
    gen_beats = 0;
    frame_no = 0;
    while (gen_beats < RANDOM_BEATS) begin
      if (frame_no % 4 == 0) begin
        settle();
        if ($urandom_range(19) == 0) reg_w = $urandom_range(2);
        else if ($urandom_range(9) == 0) reg_w = $urandom_range(40, 13);
        else reg_w = $urandom_range(12, 3);
        reg_h = ($urandom_range(19) == 0) ? $urandom_range(2) : $urandom_range(8, 3);
        write_reg(CFG_FRAME_WIDTH, reg_w);
        write_reg(CFG_FRAME_HEIGHT, reg_h);
        case ($urandom_range(3))
          0:       write_reg(CFG_MAX_VALUE, 65535);
          1:       write_reg(CFG_MAX_VALUE, $urandom_range(300));
          default: write_reg(CFG_MAX_VALUE, $urandom_range(65535));
        endcase
        w_eff = (reg_w < 3) ? 3 : reg_w;
        h_eff = (reg_h < 3) ? 3 : reg_h;
      end
      case (frame_no % 5)
        1:       set_idling(76, 0);
        2:       set_idling(0, 76);
        3:       set_idling(32, 32);
        default: set_idling(0, 0);
      endcase
      for (int unsigned i = 0; i < w_eff * h_eff; i++) begin
        if ($urandom_range(32) == 0) push_flushes(1);
        push_beat(KIND_PIXEL, rand_pixel());
      end
      gen_beats += w_eff * h_eff;
      if ($urandom_range(6) == 0)
        for (int i = 0; i < $urandom_range(3, 1); i++)
          push_beat(KIND_PIXEL, rand_pixel());
      // now and then a short drain, so the next frame is swallowed by the old one
      n = ($urandom_range(15) == 0) ? $urandom_range(w_eff) : w_eff + 1;
      push_flushes(n);
      gen_beats += n;
      if ($urandom_range(9) == 0) push_flushes(1);
      frame_no++;
      while (stim_beats.size() != 0) @(posedge clk);
    end
    settle();

    $display("Run covered %0d input beats (%0d dropped or ignored), %0d output beats, %0d frames.",
             beats_in, beats_dropped, results_seen, frames_done);
    $display("Widths 3 to 1024, heights up to 4096 by saturation, clamp 0 to 65535; %0d errors.",
             mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #(RUN_LIMIT);
    $display("Timed out with %0d beats queued and %0d results outstanding.",
             stim_beats.size(), expected_px.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
